### sv/rtp_audio_packetizer_unit_defines.svh
// ----------------------------------------------------------------------------
// RTP audio packetizer assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RTP_AUDIO_PACKETIZER_UNIT_DEFINES_SVH
`define RTP_AUDIO_PACKETIZER_UNIT_DEFINES_SVH

// Same-cycle implication, reset masked
`define RTPAP_ASSERT_NOW(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication, reset masked
`define RTPAP_ASSERT_NEXT(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

### sv/rtpap_pkg.sv
// ----------------------------------------------------------------------------
// RTP audio packetizer package
// Types, register codes and constants shared by the packetizer modules.
// ----------------------------------------------------------------------------
package rtpap_pkg;

    // sample_mode codes (code 3 behaves as raw)
    localparam logic [1:0] MODE_INT16 = 2'd0;
    localparam logic [1:0] MODE_FLOAT = 2'd1;
    localparam logic [1:0] MODE_RAW   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_MODE  = 2'd0;
    localparam logic [1:0] CFG_PT_CODE      = 2'd1;
    localparam logic [1:0] CFG_SOURCE_ID    = 2'd2;
    localparam logic [1:0] CFG_MAX_FRAMES   = 2'd3;

    // reset values
    localparam logic [1:0]  RST_SAMPLE_MODE  = 2'd0;
    localparam logic [6:0]  RST_PT_CODE      = 7'd10;
    localparam logic [31:0] RST_SOURCE_ID    = 32'h1234_5678;
    localparam logic [9:0]  RST_MAX_FRAMES   = 10'd247;

    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;

    // float to Q15 conversion
    localparam logic [14:0] Q15_SCALE  = 15'd32767;
    localparam logic [7:0]  EXP_ONE    = 8'd127;
    localparam logic [7:0]  EXP_SPEC   = 8'hFF;
    localparam logic [7:0]  SHIFT_BIAS = 8'd150;

    typedef struct packed {
        logic [1:0]  sample_mode;
        logic [6:0]  pt_code;
        logic [31:0] source_id;
        logic [9:0]  max_frames;
    } t_cfg;

    typedef struct packed {
        logic [31:0] word;
        logic        is_header;
        logic        packet_end;
    } t_word;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_DATA
    } t_phase;

endpackage

### sv/rtp_audio_packetizer_unit.sv
// ----------------------------------------------------------------------------
// RTP audio packetizer unit
// Codes stereo frames into RTP L16 payload words and prepends packet headers.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | content
//  ---------+-----------+---------------------------+---------------------------
//  s_axis   | in        | s_axis_tvalid/tready      | one stereo frame per word
//  m_axis   | out       | m_axis_tvalid/tready      | one packet word per word
//  cfg      | in        | i_cfg_valid/o_cfg_ready   | register index + data
//
//  Words: a frame inside a packet yields one payload word; the first frame of a
//  packet yields four through the single output register (three header words
//  plus the payload word). A frame passes three lane stages (multiply, round,
//  scale) and then the output register.
//  Reset: synchronous, active low; clears valid bits, packet counters and
//  the configuration registers to their defaults.
//  Stalls: the lane pipeline advances as a whole whenever its last stage is
//  empty or its frame has gone out; m_axis_tready low holds the output word.
// ----------------------------------------------------------------------------
module rtp_audio_packetizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // frame in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] left_sample, [63:32] right_sample
    input  logic        s_axis_tlast,   // end_of_buffer
    // packet words out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] packet_word
    output logic        m_axis_tuser,   // [0] is_header
    output logic        m_axis_tlast,   // packet_end
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    rtpap_pkg::t_cfg  r_cfg, n_cfg;
    rtpap_pkg::t_word out_word;

    // lane pipeline valid and end-of-buffer tracking
    logic r_v1, r_v2, r_v3;
    logic r_eob1, r_eob2, r_eob3;
    logic adv;
    logic frame_done;
    logic [15:0] left_code, right_code;

    // registers always accept a write
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                rtpap_pkg::CFG_SAMPLE_MODE:  n_cfg.sample_mode  = i_cfg_data[1:0];
                rtpap_pkg::CFG_PT_CODE:      n_cfg.pt_code      = i_cfg_data[6:0];
                rtpap_pkg::CFG_SOURCE_ID:    n_cfg.source_id    = i_cfg_data;
                rtpap_pkg::CFG_MAX_FRAMES:   n_cfg.max_frames   = i_cfg_data[9:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_mode  <= rtpap_pkg::RST_SAMPLE_MODE;
            r_cfg.pt_code      <= rtpap_pkg::RST_PT_CODE;
            r_cfg.source_id    <= rtpap_pkg::RST_SOURCE_ID;
            r_cfg.max_frames   <= rtpap_pkg::RST_MAX_FRAMES;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // whole pipeline moves when the framer frees the last stage
    assign adv           = !r_v3 || frame_done;
    assign s_axis_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_eob1 <= s_axis_tlast;
            r_eob2 <= r_eob1;
            r_eob3 <= r_eob2;
        end
    end

    // one lane per channel
    rtpap_lane u_lane_left (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_mode   (r_cfg.sample_mode),
        .i_sample (s_axis_tdata[31:0]),
        .o_code   (left_code)
    );

    rtpap_lane u_lane_right (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_mode   (r_cfg.sample_mode),
        .i_sample (s_axis_tdata[63:32]),
        .o_code   (right_code)
    );

    // merge lanes, insert headers, hold the output word
    rtpap_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v3),
        .i_eob       (r_eob3),
        .i_left      (left_code),
        .i_right     (right_code),
        .i_cfg       (r_cfg),
        .i_out_ready (m_axis_tready),
        .o_done      (frame_done),
        .o_out_valid (m_axis_tvalid),
        .o_out       (out_word)
    );

    assign m_axis_tdata = out_word.word;
    assign m_axis_tuser = out_word.is_header;
    assign m_axis_tlast = out_word.packet_end;

endmodule

### sv/rtpap_lane.sv
// ----------------------------------------------------------------------------
// RTP audio packetizer sample lane
// Three-stage coder for one channel: int16, float to Q15, or raw bytes.
// ----------------------------------------------------------------------------
module rtpap_lane (
    input  logic        i_clk,
    input  logic        i_adv,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_sample,
    output logic [15:0] o_code
);

    // stage 1: decode and multiply
    logic        r1_pass, n1_pass;
    logic        r1_special, n1_special;
    logic        r1_sgn, n1_sgn;
    logic [15:0] r1_value, n1_value;
    logic [7:0]  r1_sh, n1_sh;
    logic [38:0] r1_prod, n1_prod;

    // stage 2: round product to 24 significant bits
    logic        r2_pass, r2_special, r2_sgn;
    logic [15:0] r2_value;
    logic [7:0]  r2_sh;
    logic [39:0] r2_p, n2_p;

    // stage 3: scale down, sign, select
    logic [15:0] r3_code, n3_code;

    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] q;
    logic [14:0] rem;
    logic [14:0] half;
    logic        rnd;
    logic [24:0] q_inc;
    logic [39:0] shifted;
    logic [15:0] mag;

    always_comb begin
        ex         = i_sample[30:23];
        man        = i_sample[22:0];
        n1_pass    = 1'b1;
        n1_special = 1'b0;
        n1_sgn     = 1'b0;
        n1_value   = '0;
        n1_sh      = 8'(rtpap_pkg::SHIFT_BIAS - ex);
        n1_prod    = 39'({1'b1, man}) * 39'(rtpap_pkg::Q15_SCALE);
        case (i_mode)
            rtpap_pkg::MODE_INT16: begin
                n1_value = i_sample[15:0];
            end
            rtpap_pkg::MODE_FLOAT: begin
                n1_pass = 1'b0;
                n1_sgn  = i_sample[31];
                if (ex == rtpap_pkg::EXP_SPEC && man != '0) begin
                    // NaN codes as zero, no sign
                    n1_special = 1'b1;
                    n1_sgn     = 1'b0;
                end else if (ex >= rtpap_pkg::EXP_ONE) begin
                    n1_special = 1'b1;
                    n1_value   = 16'(rtpap_pkg::Q15_SCALE);
                end else if (ex == '0) begin
                    n1_special = 1'b1;
                end
            end
            default: begin
                n1_value = {i_sample[7:0], i_sample[15:8]};
            end
        endcase
    end

    always_comb begin
        if (r1_prod[38]) begin
            q    = r1_prod[38:15];
            rem  = r1_prod[14:0];
            half = 15'h4000;
        end else begin
            q    = r1_prod[37:14];
            rem  = {1'b0, r1_prod[13:0]};
            half = 15'h2000;
        end
        rnd   = (rem > half) || (rem == half && q[0]);
        q_inc = 25'(q) + 25'(rnd);
        n2_p  = r1_prod[38] ? (40'(q_inc) << 15) : (40'(q_inc) << 14);
    end

    always_comb begin
        shifted = r2_p >> r2_sh;
        mag     = r2_special ? r2_value : shifted[15:0];
        if (r2_pass) begin
            n3_code = r2_value;
        end else if (r2_sgn) begin
            n3_code = ~mag + 16'd1;
        end else begin
            n3_code = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_pass    <= n1_pass;
            r1_special <= n1_special;
            r1_sgn     <= n1_sgn;
            r1_value   <= n1_value;
            r1_sh      <= n1_sh;
            r1_prod    <= n1_prod;
            r2_pass    <= r1_pass;
            r2_special <= r1_special;
            r2_sgn     <= r1_sgn;
            r2_value   <= r1_value;
            r2_sh      <= r1_sh;
            r2_p       <= n2_p;
            r3_code    <= n3_code;
        end
    end

    assign o_code = r3_code;

endmodule

### sv/rtpap_framer.sv
// ----------------------------------------------------------------------------
// RTP audio packetizer framer
// Merges lane results into payload words, inserts headers, tracks packets.
// ----------------------------------------------------------------------------
module rtpap_framer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_eob,
    input  logic [15:0]        i_left,
    input  logic [15:0]        i_right,
    input  rtpap_pkg::t_cfg    i_cfg,
    input  logic               i_out_ready,
    output logic               o_done,
    output logic               o_out_valid,
    output rtpap_pkg::t_word   o_out
);

    rtpap_pkg::t_phase r_phase, n_phase;
    logic [15:0]       r_seq, n_seq;
    logic [31:0]       r_ts, n_ts;
    logic [9:0]        r_cnt, n_cnt;
    logic              r_o_valid, n_o_valid;
    rtpap_pkg::t_word  r_o, n_o;

    logic              out_free;
    logic              emit;
    logic [10:0]       count;
    logic              close;
    rtpap_pkg::t_word  word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rtpap_pkg::PH_HDR0;
            r_seq     <= '0;
            r_ts      <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_seq     <= n_seq;
            r_ts      <= n_ts;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o <= n_o;
    end

    always_comb begin
        out_free = !r_o_valid || i_out_ready;
        emit     = i_valid && out_free;
        count    = 11'(r_cnt) + 11'd1;
        close    = i_eob || (count >= 11'(i_cfg.max_frames));
        n_phase  = r_phase;
        n_seq    = r_seq;
        n_ts     = r_ts;
        n_cnt    = r_cnt;
        o_done   = 1'b0;
        word     = '0;
        case (r_phase)
            rtpap_pkg::PH_HDR0: begin
                word.word      = {rtpap_pkg::RTP_VERSION_BYTE, 1'b0,
                                  i_cfg.pt_code, r_seq};
                word.is_header = 1'b1;
                if (emit) n_phase = rtpap_pkg::PH_HDR1;
            end
            rtpap_pkg::PH_HDR1: begin
                word.word      = r_ts;
                word.is_header = 1'b1;
                if (emit) n_phase = rtpap_pkg::PH_HDR2;
            end
            rtpap_pkg::PH_HDR2: begin
                word.word      = i_cfg.source_id;
                word.is_header = 1'b1;
                if (emit) n_phase = rtpap_pkg::PH_DATA;
            end
            rtpap_pkg::PH_DATA: begin
                word.word       = {i_left, i_right};
                word.packet_end = close;
                if (emit) begin
                    o_done = 1'b1;
                    n_ts   = r_ts + 32'd1;
                    if (close) begin
                        n_seq   = r_seq + 16'd1;
                        n_cnt   = '0;
                        n_phase = rtpap_pkg::PH_HDR0;
                    end else begin
                        n_cnt = count[9:0];
                    end
                end
            end
            default: begin
                n_phase = rtpap_pkg::PH_HDR0;
            end
        endcase
        n_o_valid = emit || (r_o_valid && !i_out_ready);
        n_o       = emit ? word : r_o;
    end

    assign o_out_valid = r_o_valid;
    assign o_out       = r_o;

endmodule

### sv/rtpap_checker.sv
// ----------------------------------------------------------------------------
// RTP audio packetizer port checker
// Watches the output stream for packet structure and stall behavior.
// ----------------------------------------------------------------------------
`include "rtp_audio_packetizer_unit_defines.svh"

module rtpap_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    logic       out_acc;
    logic [1:0] r_hcnt;
    logic       r_need_hdr;

    assign out_acc = m_axis_tvalid && m_axis_tready;

    // header words seen in a row, and whether a new packet must start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcnt     <= '0;
            r_need_hdr <= 1'b1;
        end else if (out_acc) begin
            r_hcnt     <= m_axis_tuser ? r_hcnt + 2'd1 : 2'd0;
            r_need_hdr <= !m_axis_tuser && m_axis_tlast;
        end
    end

    `RTPAP_ASSERT_NOW(a_pkt_starts_hdr, i_clk, i_rst_n, out_acc && r_need_hdr, m_axis_tuser, "packet does not open with a header")
    `RTPAP_ASSERT_NOW(a_hdr_version, i_clk, i_rst_n, out_acc && m_axis_tuser && r_hcnt == 2'd0, m_axis_tdata[31:24] == 8'h80, "first header word lacks version byte")
    `RTPAP_ASSERT_NOW(a_hdr_len, i_clk, i_rst_n, out_acc && m_axis_tuser, r_hcnt != 2'd3 && !m_axis_tlast, "header run longer than three words or marked last")
    `RTPAP_ASSERT_NOW(a_hdr_whole, i_clk, i_rst_n, out_acc && !m_axis_tuser, r_hcnt == 2'd0 || r_hcnt == 2'd3, "payload after a partial header")
    `RTPAP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

endmodule

bind rtp_audio_packetizer_unit rtpap_checker u_rtpap_checker (.*);

### verif/rtp_audio_packetizer_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTP audio packetizer checker
// Watches the frame, packet and register channels. Each accepted frame is
// turned into its expected packet words, and each word that leaves the block
// is compared with the oldest of them.
// ----------------------------------------------------------------------------
module rtp_audio_packetizer_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] left_sample, [63:32] right_sample
    input  logic        s_axis_tlast,   // end_of_buffer
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] packet_word
    input  logic        m_axis_tuser,   // [0] is_header
    input  logic        m_axis_tlast,   // packet_end
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    rtpap_pkg::t_cfg  regs;
    logic [15:0]      seq_no;
    logic [31:0]      rtp_time;
    logic [9:0]       frames_open;
    rtpap_pkg::t_word packet_words[$];
    int               error_count = 0;

    assign o_errors = error_count;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // single-precision product, rounded to nearest even, then truncated
    function automatic logic [15:0] float_to_pcm16(input logic [31:0] bits);
        logic [7:0]  ex;
        logic [22:0] man;
        logic [63:0] prod;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] half;
        logic [15:0] mag;
        int          len;
        int          d;
        int          sh;
        ex  = bits[30:23];
        man = bits[22:0];
        if (ex == 8'hFF && man != 0)
            return 16'h0000;                    // NaN
        if (ex >= 8'd127) begin
            mag = 16'd32767;                    // |x| >= 1, infinities too
        end else if (ex == 8'd0) begin
            mag = 16'd0;                        // zero and subnormals
        end else begin
            prod = {40'd0, 1'b1, man} * 64'd32767;
            len = 0;
            for (int i = 0; i < 64; i++)
                if (prod[i]) len = i + 1;
            d    = len - 24;
            q    = prod >> d;
            r    = prod & ((64'd1 << d) - 64'd1);
            half = 64'd1 << (d - 1);
            if (r > half || (r == half && q[0]))
                q = q + 64'd1;
            prod = q << d;
            sh   = 150 - int'(ex);
            mag  = (sh < 64) ? 16'(prod >> sh) : 16'd0;
        end
        return bits[31] ? 16'(16'd0 - mag) : mag;
    endfunction

    function automatic logic [15:0] lane_value(input logic [31:0] s);
        case (regs.sample_mode)
            rtpap_pkg::MODE_INT16: return s[15:0];
            rtpap_pkg::MODE_FLOAT: return float_to_pcm16(s);
            default:               return {s[7:0], s[15:8]};   // raw, and code 3 as raw
        endcase
    endfunction

    task automatic push_word(input logic [31:0] w, input logic hdr, input logic last);
        rtpap_pkg::t_word e;
        e.word       = w;
        e.is_header  = hdr;
        e.packet_end = last;
        packet_words.push_back(e);
    endtask

    task automatic predict_frame(input logic [31:0] left, input logic [31:0] right,
                                 input logic eob);
        int   count;
        logic close;
        if (frames_open == 0) begin
            push_word({rtpap_pkg::RTP_VERSION_BYTE, 1'b0, regs.pt_code, seq_no},
                      1'b1, 1'b0);
            push_word(rtp_time, 1'b1, 1'b0);
            push_word(regs.source_id, 1'b1, 1'b0);
        end
        count = int'(frames_open) + 1;
        close = eob || (count >= int'(regs.max_frames));
        push_word({lane_value(left), lane_value(right)}, 1'b0, close);
        rtp_time = rtp_time + 32'd1;
        if (close) begin
            seq_no      = seq_no + 16'd1;
            frames_open = '0;
        end else begin
            frames_open = count[9:0];
        end
    endtask

    task automatic check_word();
        rtpap_pkg::t_word e;
        if (packet_words.size() == 0) begin
            report("word with nothing expected", m_axis_tdata, 32'd0);
            return;
        end
        e = packet_words.pop_front();
        if (m_axis_tdata !== e.word)
            report("packet_word", m_axis_tdata, e.word);
        if (m_axis_tuser !== e.is_header)
            report("is_header", {31'd0, m_axis_tuser}, {31'd0, e.is_header});
        if (m_axis_tlast !== e.packet_end)
            report("packet_end", {31'd0, m_axis_tlast}, {31'd0, e.packet_end});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.sample_mode  = rtpap_pkg::RST_SAMPLE_MODE;
            regs.pt_code      = rtpap_pkg::RST_PT_CODE;
            regs.source_id    = rtpap_pkg::RST_SOURCE_ID;
            regs.max_frames   = rtpap_pkg::RST_MAX_FRAMES;
            seq_no      = '0;
            rtp_time    = '0;
            frames_open = '0;
            packet_words.delete();
            o_pending <= 0;
        end else begin
            // outgoing word first: it always belongs to an earlier frame
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rtpap_pkg::CFG_SAMPLE_MODE: regs.sample_mode = i_cfg_data[1:0];
                    rtpap_pkg::CFG_PT_CODE:     regs.pt_code     = i_cfg_data[6:0];
                    rtpap_pkg::CFG_SOURCE_ID:   regs.source_id   = i_cfg_data;
                    rtpap_pkg::CFG_MAX_FRAMES:  regs.max_frames  = i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_frame(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
            o_pending <= packet_words.size();
        end
    end

endmodule

### verif/rtp_audio_packetizer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTP audio packetizer testbench
// Drives stereo frames and register writes into the packetizer under random
// bursts and output stalls; a checker beside the block predicts every packet
// word and counts mismatches. Directed frames cover sample extremes, float
// special values and packet closing rules, then random phases follow.
// ----------------------------------------------------------------------------
module rtp_audio_packetizer_unit_tb;

    // sample_mode code 3 has no name in the package; the block treats it as raw
    localparam logic [1:0] MODE_RAW_ALT = 2'd3;

    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;  // idle cycles with no word moving
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_FRAMES   = 56;

    // receiver stall patterns
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} t_rx_mode;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;

    int       mismatches;
    int       words_pending;
    int       burst_left = 0;
    int       idle_cycles = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;

    rtp_audio_packetizer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    rtp_audio_packetizer_unit_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (mismatches),
        .o_pending     (words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: a stall pattern is held for a random stretch, then another one
    // is drawn. RX_OPEN gives stretches with no back-pressure at all.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 64);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:  m_axis_tready <= 1'b1;
            RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_HALF:  m_axis_tready <= ($urandom_range(0, 1) != 0);
            default:  m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Watchdog: any word moving on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // One frame. Sender works in bursts; a gap of idle cycles, if any, opens each one.
    // tvalid stays high after the handshake so back-to-back frames need no
    // second assignment in the same step.
    task automatic send_frame(input logic [31:0] left, input logic [31:0] right,
                              input logic eob);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        s_axis_tlast  <= eob;
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
        burst_left--;
    endtask

    // Register write; i_cfg_valid is left high for a following write.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready)) @(posedge i_clk);
    endtask

    // Stop sending, then wait until every predicted word has left the block.
    // The first edge lets the checker see a frame taken in this very step.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
    endtask

    // Registers are only touched once the block has nothing in flight; every
    // frame yields at least one word, so a drained queue means an idle block.
    task automatic set_registers(input logic [1:0] mode, input logic [6:0] pt,
                                 input logic [31:0] ssrc, input logic [9:0] maxf);
        wait_drained();
        write_reg(rtpap_pkg::CFG_SAMPLE_MODE, {30'd0, mode});
        write_reg(rtpap_pkg::CFG_PT_CODE, {25'd0, pt});
        write_reg(rtpap_pkg::CFG_SOURCE_ID, ssrc);
        write_reg(rtpap_pkg::CFG_MAX_FRAMES, {22'd0, maxf});
        i_cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    // Float samples lean toward the [-1,1] range and its edges, with some
    // special encodings and fully random patterns mixed in.
    function automatic logic [31:0] make_sample(input logic [1:0] mode);
        logic [31:0] specials [0:9];
        logic [7:0]  ex;
        specials = '{32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                     32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                     32'h3F80_0000, 32'hBF80_0000};
        if (mode != rtpap_pkg::MODE_FLOAT)
            return $urandom;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return specials[$urandom_range(0, 9)];
            default: begin
                ex = 8'($urandom_range(100, 128));
                return {1'($urandom_range(0, 1)), ex, 23'($urandom)};
            end
        endcase
    endfunction

    task automatic random_phase(input int n_frames);
        logic [1:0]  mode;
        logic [6:0]  pt;
        logic [9:0]  maxf;
        logic [31:0] left;
        logic [31:0] right;
        logic        eob;
        case ($urandom_range(0, 4))
            0:       mode = rtpap_pkg::MODE_INT16;
            1, 2:    mode = rtpap_pkg::MODE_FLOAT;
            3:       mode = rtpap_pkg::MODE_RAW;
            default: mode = MODE_RAW_ALT;
        endcase
        case ($urandom_range(0, 3))
            0:       pt = 7'd0;
            1:       pt = 7'd127;
            default: pt = 7'($urandom);
        endcase
        // mostly short packets so headers come often
        case ($urandom_range(0, 9))
            0:       maxf = 10'd0;
            1:       maxf = 10'd1;
            2:       maxf = 10'd1023;
            3:       maxf = 10'($urandom);
            default: maxf = 10'($urandom_range(1, 8));
        endcase
        set_registers(mode, pt, $urandom, maxf);
        for (int i = 0; i < n_frames; i++) begin
            left  = make_sample(mode);
            right = make_sample(mode);
            eob   = ($urandom_range(0, 15) == 0);
            send_frame(left, right, eob);
        end
    endtask

    initial begin
        logic [31:0] float_cases [0:13];
        float_cases = '{32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
                        32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
                        32'h0000_0001, 32'h807F_FFFF, 32'h3F00_0000, 32'h4000_0000,
                        32'h3F7F_FFFF, 32'h37FF_FFFF};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: int16 extremes, upper halves ignored, buffer end closes
        send_frame(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_frame(32'h0000_8000, 32'hFFFF_7FFF, 1'b1);

        // float: ones, infinities, NaNs, signed zeros, subnormals, halfway cases
        set_registers(rtpap_pkg::MODE_FLOAT, 7'd127, 32'hFFFF_FFFF, 10'd1023);
        for (int i = 0; i < 14; i += 2)
            send_frame(float_cases[i], float_cases[i + 1], (i == 12));

        // raw: packet closes on the frame count
        set_registers(rtpap_pkg::MODE_RAW, 7'd0, 32'h0000_0000, 10'd4);
        send_frame(32'h0000_1234, 32'hABCD_00FF, 1'b0);
        send_frame(32'hFFFF_FF00, 32'h0000_00FF, 1'b0);
        send_frame(32'h5A5A_A5A5, 32'hA5A5_5A5A, 1'b0);
        send_frame(32'h8001_7FFE, 32'h7FFE_8001, 1'b0);

        // limit lowered below the open packet's count: next frame closes it
        set_registers(rtpap_pkg::MODE_INT16, 7'd96, $urandom, 10'd8);
        send_frame($urandom, $urandom, 1'b0);
        send_frame($urandom, $urandom, 1'b0);
        send_frame($urandom, $urandom, 1'b0);
        set_registers(rtpap_pkg::MODE_INT16, 7'd96, $urandom, 10'd2);
        send_frame($urandom, $urandom, 1'b0);

        // limit zero: every frame is a packet of its own
        set_registers(rtpap_pkg::MODE_INT16, 7'd33, $urandom, 10'd0);
        send_frame($urandom, $urandom, 1'b0);
        send_frame($urandom, $urandom, 1'b0);

        // mode code 3 falls back to raw
        set_registers(MODE_RAW_ALT, 7'd5, $urandom, 10'd1023);
        send_frame($urandom, $urandom, 1'b0);
        send_frame($urandom, $urandom, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(PHASE_FRAMES);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
